/* rtl/core/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, operation codes, cell codes and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic REG_ATTR   = 1'b0;
  localparam logic REG_MARKER = 1'b1;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MARKER  = 8'h5F;
  localparam logic [ATTR_W-1:0] ATTR_MARKER  = 8'h00;
  localparam int               TAB_STOP     = 8;

  typedef logic [CELL_W-1:0] cell_t;

  localparam cell_t MARKER_CELL = {ATTR_MARKER, CHAR_MARKER};
  localparam cell_t ZERO_CELL   = '0;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_SCROLL,
    RD_CELL
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ZERO,
    WR_BLANK,
    WR_PUT,
    WR_CELL,
    WR_PIPE,
    WR_ERASE,
    WR_MARK
  } wr_sel_t;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_NEXT,
    POS_BOTTOM,
    POS_CELL,
    POS_ZERO
  } pos_sel_t;

  typedef struct packed {
    logic     load;
    logic     idx_clr;
    logic     step;
    logic     rd_en;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    pos_sel_t pos_sel;
    logic     set_bad;
    logic     set_scroll;
    logic     cap_read;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_nl;
    logic            is_tab;
    logic            in_range;
    logic            next_ovf;
    logic            idx_last;
    logic            pipe_last;
    logic            scan_hit;
    logic            out_busy;
  } stat_t;

endpackage

/* rtl/core/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console with scrolling
// Screen memory of COLUMNS x ROWS char/attribute cells, print position,
// register port for attribute and cursor marker mode.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | op, char_code, col, row
//   out     | output    | out_valid/out_stall | cursor_col, cursor_row,
//           |           |                     | cell_char, cell_attr,
//           |           |                     | scrolled, bad_position
//   config  | input     | APB psel/penable    | text_attribute, marker mode
//
// One item at a time. Put char, write and set cursor without marker pass
// through decode and finish; read cell adds a read step. Scroll and clear
// screen sweep the memory, one memory cell per cycle; set cursor in marker
// mode adds a scan for the marker.
// After reset the memory is zero-filled with in_stall high. A new item is
// taken while the previous result waits in the output register; a stalled
// output holds the next result in its last step.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [COL_W-1:0]   col,
  input  logic [ROW_W-1:0]   row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COL_W-1:0]   cursor_col,
  output logic [ROW_W-1:0]   cursor_row,
  output logic [CHAR_W-1:0]  cell_char,
  output logic [ATTR_W-1:0]  cell_attr,
  output logic               scrolled,
  output logic               bad_position
);

  logic [ATTR_W-1:0] text_attribute;
  logic              cursor_marker_mode;
  logic              reg_wr;
  logic              reg_sel;
  cmd_t              cmd;
  stat_t             st;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute     <= ATTR_RESET;
      cursor_marker_mode <= 1'b0;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_ATTR:   text_attribute <= pwdata[ATTR_W-1:0];
        REG_MARKER: cursor_marker_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ATTR:   prdata = DATA_W'(text_attribute);
      REG_MARKER: prdata = DATA_W'(cursor_marker_mode);
      default:    prdata = '0;
    endcase
  end

  tcw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .marker_mode (cursor_marker_mode),
    .st          (st),
    .cmd         (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .attr         (text_attribute),
    .marker_mode  (cursor_marker_mode),
    .op           (op),
    .char_code    (char_code),
    .col          (col),
    .row          (row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cursor_col   (cursor_col),
    .cursor_row   (cursor_row),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .scrolled     (scrolled),
    .bad_position (bad_position)
  );

endmodule

/* rtl/core/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: operation sequencer
// Steps each item through decode, screen sweeps (reset fill, clear, scroll,
// marker search) and the result hand-off to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  marker_mode,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_SCROLL = 4'd3;
  localparam logic [3:0] S_CLEAR  = 4'd4;
  localparam logic [3:0] S_SEARCH = 4'd5;
  localparam logic [3:0] S_MARK   = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state, state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RD_IDX;
    cmd.wr_sel  = WR_NONE;
    cmd.pos_sel = POS_HOLD;
    state_next  = state;
    case (state)
      S_INIT: begin
        cmd.wr_sel = WR_ZERO;
        cmd.step   = 1'b1;
        if (st.idx_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = accept;
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = S_FINISH;
        case (st.op)
          OP_PUT: begin
            if (!st.is_nl && !st.is_tab) cmd.wr_sel = WR_PUT;
            if (st.next_ovf) begin
              cmd.pos_sel    = POS_BOTTOM;
              cmd.set_scroll = 1'b1;
              cmd.idx_clr    = 1'b1;
              state_next     = S_SCROLL;
            end else begin
              cmd.pos_sel = POS_NEXT;
            end
          end
          OP_SET: begin
            if (!st.in_range) begin
              cmd.set_bad = 1'b1;
            end else if (marker_mode) begin
              cmd.idx_clr = 1'b1;
              state_next  = S_SEARCH;
            end else begin
              cmd.pos_sel = POS_CELL;
            end
          end
          OP_CLEAR: begin
            cmd.idx_clr = 1'b1;
            state_next  = S_CLEAR;
          end
          OP_WRITE: begin
            if (!st.in_range) cmd.set_bad = 1'b1;
            else cmd.wr_sel = WR_CELL;
          end
          OP_READ: begin
            if (!st.in_range) begin
              cmd.set_bad = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_CELL;
              state_next = S_READ;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_SCROLL: begin
        cmd.step   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SCROLL;
        cmd.wr_sel = WR_PIPE;
        if (st.pipe_last) state_next = S_FINISH;
      end
      S_CLEAR: begin
        cmd.step   = 1'b1;
        cmd.wr_sel = WR_BLANK;
        if (st.idx_last) begin
          cmd.pos_sel = POS_ZERO;
          state_next  = S_FINISH;
        end
      end
      S_SEARCH: begin
        cmd.step   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        if (st.scan_hit) begin
          cmd.wr_sel = WR_ERASE;
          state_next = S_MARK;
        end else if (st.pipe_last) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        cmd.wr_sel  = WR_MARK;
        cmd.pos_sel = POS_CELL;
        state_next  = S_FINISH;
      end
      S_READ: begin
        cmd.cap_read = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_busy)
    else $error("result loaded over a pending result");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DECODE)
    else $error("accepted item not decoded");

  a_scroll_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) && !st.pipe_last |=> state == S_SCROLL)
    else $error("scroll left before last cell");

endmodule

/* rtl/core/tcw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath: screen memory, print position and result registers
// Holds the cell memory, the sweep index with its registered write pipe,
// the print position and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic [ATTR_W-1:0] attr,
  input  logic              marker_mode,
  input  logic [OP_W-1:0]   op,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  cursor_col,
  output logic [ROW_W-1:0]  cursor_row,
  output logic [CHAR_W-1:0] cell_char,
  output logic [ATTR_W-1:0] cell_attr,
  output logic              scrolled,
  output logic              bad_position
);

  localparam int N  = COLUMNS * ROWS;
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = $clog2(N);
  localparam int LW = $clog2(N + 1);
  localparam int SW = LW + 1;

  cell_t mem [N];
  cell_t rdata;
  cell_t wdata;
  cell_t blank;
  logic  we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic [OP_W-1:0]   op_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  logic [CW-1:0] pos_col;
  logic [RW-1:0] pos_row;
  logic [AW-1:0] pos_lin;

  logic [LW-1:0] idx;
  logic [LW-1:0] scroll_ra;
  logic          pipe_v;
  logic          pipe_copy;
  logic [AW-1:0] pipe_addr;

  logic              res_bad;
  logic              res_scroll;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;

  logic [LW-1:0] in_lin;
  logic          in_range;
  logic          is_nl;
  logic          is_tab;
  logic [3:0]    tab_amt;
  logic [3:0]    step_amt;
  logic [SW-1:0] nxt_lin;
  logic [CW:0]   col_sum;
  logic          col_wrap;
  logic [CW-1:0] nxt_col;
  logic [RW-1:0] nxt_row;

  assign blank    = {attr, CHAR_BLANK};
  assign in_range = (32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS));
  assign in_lin   = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);
  assign is_nl    = (char_q == CHAR_NEWLINE);
  assign is_tab   = (char_q == CHAR_TAB);

  // next print position for put char
  assign tab_amt  = 4'(TAB_STOP) - {1'b0, pos_lin[2:0]};
  assign step_amt = is_tab ? tab_amt : 4'd1;
  assign col_sum  = (CW + 1)'(pos_col) + (CW + 1)'(step_amt);
  assign col_wrap = col_sum >= (CW + 1)'(COLUMNS);

  always_comb begin
    if (is_nl) begin
      nxt_lin = SW'(pos_lin) + SW'(COLUMNS) - SW'(pos_col);
      nxt_col = '0;
      nxt_row = pos_row + RW'(1);
    end else begin
      nxt_lin = SW'(pos_lin) + SW'(step_amt);
      if (col_wrap) begin
        nxt_col = CW'(col_sum - (CW + 1)'(COLUMNS));
        nxt_row = pos_row + RW'(1);
      end else begin
        nxt_col = col_sum[CW-1:0];
        nxt_row = pos_row;
      end
    end
  end

  assign scroll_ra = idx + LW'(COLUMNS);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    raddr = idx[AW-1:0];
      RD_SCROLL: raddr = scroll_ra[AW-1:0];
      RD_CELL:   raddr = in_lin[AW-1:0];
      default:   raddr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx[AW-1:0];
    wdata = blank;
    case (cmd.wr_sel)
      WR_NONE:  we = 1'b0;
      WR_ZERO:  wdata = ZERO_CELL;
      WR_BLANK: wdata = (marker_mode && idx == '0) ? MARKER_CELL : blank;
      WR_PUT: begin
        waddr = pos_lin;
        wdata = {attr, char_q};
      end
      WR_CELL: begin
        waddr = in_lin[AW-1:0];
        wdata = {attr, char_q};
      end
      WR_PIPE: begin
        we    = pipe_v;
        waddr = pipe_addr;
        wdata = pipe_copy ? rdata : blank;
      end
      WR_ERASE: waddr = pipe_addr;
      WR_MARK: begin
        waddr = in_lin[AW-1:0];
        wdata = MARKER_CELL;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata <= mem[raddr];
  end

  // sweep index and the write pipe that writes each cell in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      pipe_v <= 1'b0;
    end else begin
      pipe_v <= cmd.step && (idx != LW'(N));
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.step && idx != LW'(N)) begin
        idx <= idx + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr <= idx[AW-1:0];
    pipe_copy <= idx < LW'(N - COLUMNS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      char_q <= char_code;
      col_q  <= col;
      row_q  <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_col <= '0;
      pos_row <= '0;
      pos_lin <= '0;
    end else begin
      case (cmd.pos_sel)
        POS_HOLD: ;
        POS_NEXT: begin
          pos_col <= nxt_col;
          pos_row <= nxt_row;
          pos_lin <= nxt_lin[AW-1:0];
        end
        POS_BOTTOM: begin
          pos_col <= '0;
          pos_row <= RW'(ROWS - 1);
          pos_lin <= AW'((ROWS - 1) * COLUMNS);
        end
        POS_CELL: begin
          pos_col <= CW'(col_q);
          pos_row <= RW'(row_q);
          pos_lin <= in_lin[AW-1:0];
        end
        POS_ZERO: begin
          pos_col <= '0;
          pos_row <= '0;
          pos_lin <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_bad    <= 1'b0;
      res_scroll <= 1'b0;
      res_char   <= '0;
      res_attr   <= '0;
    end else begin
      if (cmd.set_bad) res_bad <= 1'b1;
      if (cmd.set_scroll) res_scroll <= 1'b1;
      if (cmd.cap_read) begin
        res_char <= rdata[CHAR_W-1:0];
        res_attr <= rdata[CELL_W-1:CHAR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_col   <= COL_W'(pos_col);
      cursor_row   <= ROW_W'(pos_row);
      cell_char    <= res_char;
      cell_attr    <= res_attr;
      scrolled     <= res_scroll;
      bad_position <= res_bad;
    end
  end

  assign st.op        = op_q;
  assign st.is_nl     = is_nl;
  assign st.is_tab    = is_tab;
  assign st.in_range  = in_range;
  assign st.next_ovf  = nxt_lin >= SW'(N);
  assign st.idx_last  = (idx == LW'(N - 1));
  assign st.pipe_last = pipe_v && (pipe_addr == AW'(N - 1));
  assign st.scan_hit  = pipe_v && (rdata == MARKER_CELL);
  assign st.out_busy  = out_valid && out_stall;

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos_col) < 32'(COLUMNS))
    else $error("print column out of range");

  a_pos_linear: assert property (@(posedge clk) disable iff (rst)
    LW'(pos_lin) == LW'(pos_row) * LW'(COLUMNS) + LW'(pos_col))
    else $error("linear position out of step with row and column");

  a_pipe_trails: assert property (@(posedge clk) disable iff (rst)
    pipe_v |-> (LW'(pipe_addr) + LW'(1) == idx))
    else $error("write pipe lost track of sweep index");

endmodule
